@@ hdl/adc24_pkg.sv @@
// Shared types and constants for the 24-bit serial converter reader.
package adc24_pkg;

   localparam int DATA_BITS_DEF = 24;
   localparam int OUT_W         = 24;
   localparam int EXT_W         = 32;
   localparam int MS_W          = 10;
   localparam int WAKE_W        = 8;
   localparam int REQ_W         = 3;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 10;

   localparam logic [MS_W-1:0]   MS_MAX            = 10'd1023;
   localparam logic [MS_W-1:0]   READ_TIMEOUT_RST  = 10'd120;
   localparam logic [MS_W-1:0]   INIT_TIMEOUT_RST  = 10'd200;
   localparam logic [WAKE_W-1:0] WAKE_DELAY_RST    = 8'd2;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PDOWN = 3'd2;
   localparam logic [REQ_W-1:0] REQ_WAKE  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_INIT  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_READ_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_DELAY   = 2'd2;

   typedef struct packed {
      logic [MS_W-1:0]   read_timeout_ms;
      logic [MS_W-1:0]   init_timeout_ms;
      logic [WAKE_W-1:0] wake_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic              clock_pin;
      logic              power_pin;
      logic              busy_res;
      logic              done_res;
      logic              status;
      logic [OUT_W-1:0]  sample_value;
   } rsp_type;

endpackage

@@ hdl/adc24_seq.sv @@
// Tick sequencer: pin state machine, shift register and millisecond counter.
module adc24_seq #(
   parameter int DATA_BITS = adc24_pkg::DATA_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [adc24_pkg::REQ_W-1:0]    req_type,
   input  logic                           data_pin,
   input  logic                           ms_strobe,
   input  adc24_pkg::cfg_type             cfg,
   output adc24_pkg::rsp_type             rsp
);

   localparam int CNT_W = $clog2(DATA_BITS + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RD_WAIT,
      PH_RD_HIGH,
      PH_RD_SAMPLE,
      PH_EXTRA_HIGH,
      PH_EXTRA_LOW,
      PH_WAKE,
      PH_INIT_PD,
      PH_INIT_WAKE,
      PH_INIT_WAIT
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [DATA_BITS-1:0]          shift_ff, shift_in;
   logic [CNT_W-1:0]              bit_ff, bit_in;
   logic [adc24_pkg::MS_W-1:0]    ms_ff, ms_in, ms_inc, limit;
   logic                          clk_lvl_ff, clk_lvl_in;
   logic                          pwr_lvl_ff, pwr_lvl_in;
   logic [adc24_pkg::OUT_W-1:0]   last_ff, last_in;
   logic [adc24_pkg::EXT_W-1:0]   ext_word;
   logic                          done, stat;

   assign ms_inc = (ms_strobe && (ms_ff != adc24_pkg::MS_MAX)) ?
                   ms_ff + 1'b1 : ms_ff;
   assign ext_word = adc24_pkg::EXT_W'($signed(shift_ff));

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      bit_in     = bit_ff;
      ms_in      = ms_ff;
      clk_lvl_in = clk_lvl_ff;
      pwr_lvl_in = pwr_lvl_ff;
      last_in    = last_ff;
      done       = 1'b0;
      stat       = 1'b0;
      limit      = (phase_ff == PH_RD_WAIT) ? cfg.read_timeout_ms : cfg.init_timeout_ms;
      case (phase_ff)
         PH_IDLE: begin
            case (req_type)
               adc24_pkg::REQ_READ: begin
                  ms_in    = '0;
                  phase_in = PH_RD_WAIT;
               end
               adc24_pkg::REQ_PDOWN: begin
                  clk_lvl_in = 1'b0;
                  pwr_lvl_in = 1'b0;
                  done       = 1'b1;
               end
               adc24_pkg::REQ_WAKE: begin
                  pwr_lvl_in = 1'b1;
                  ms_in      = '0;
                  phase_in   = PH_WAKE;
               end
               adc24_pkg::REQ_INIT: begin
                  clk_lvl_in = 1'b0;
                  pwr_lvl_in = 1'b0;
                  phase_in   = PH_INIT_PD;
               end
               default: ;
            endcase
         end
         PH_RD_WAIT, PH_INIT_WAIT: begin
            if (!data_pin) begin
               if (phase_ff == PH_RD_WAIT) begin
                  shift_in   = '0;
                  bit_in     = '0;
                  clk_lvl_in = 1'b1;
                  phase_in   = PH_RD_SAMPLE;
               end else begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end else begin
               ms_in = ms_inc;
               if (ms_inc >= limit) begin
                  done     = 1'b1;
                  stat     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_RD_HIGH: begin
            clk_lvl_in = 1'b1;
            phase_in   = PH_RD_SAMPLE;
         end
         PH_RD_SAMPLE: begin
            shift_in   = {shift_ff[DATA_BITS-2:0], data_pin};
            clk_lvl_in = 1'b0;
            bit_in     = bit_ff + 1'b1;
            phase_in   = (bit_in >= CNT_W'(DATA_BITS)) ? PH_EXTRA_HIGH : PH_RD_HIGH;
         end
         PH_EXTRA_HIGH: begin
            clk_lvl_in = 1'b1;
            phase_in   = PH_EXTRA_LOW;
         end
         PH_EXTRA_LOW: begin
            last_in    = ext_word[adc24_pkg::OUT_W-1:0];
            clk_lvl_in = 1'b0;
            done       = 1'b1;
            phase_in   = PH_IDLE;
         end
         PH_WAKE, PH_INIT_WAKE: begin
            ms_in = ms_inc;
            if (ms_inc >= adc24_pkg::MS_W'(cfg.wake_delay_ms)) begin
               if (phase_ff == PH_WAKE) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  ms_in    = '0;
                  phase_in = PH_INIT_WAIT;
               end
            end
         end
         PH_INIT_PD: begin
            pwr_lvl_in = 1'b1;
            ms_in      = '0;
            phase_in   = PH_INIT_WAKE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign rsp.clock_pin    = clk_lvl_in;
   assign rsp.power_pin    = pwr_lvl_in;
   assign rsp.busy_res     = (phase_in != PH_IDLE);
   assign rsp.done_res     = done;
   assign rsp.status       = stat;
   assign rsp.sample_value = last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         shift_ff   <= '0;
         bit_ff     <= '0;
         ms_ff      <= '0;
         clk_lvl_ff <= 1'b0;
         pwr_lvl_ff <= 1'b0;
         last_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         bit_ff     <= bit_in;
         ms_ff      <= ms_in;
         clk_lvl_ff <= clk_lvl_in;
         pwr_lvl_ff <= pwr_lvl_in;
         last_ff    <= last_in;
      end
   end

endmodule

@@ hdl/adc24_out_buf.sv @@
// Result register with one skid entry between the sequencer and the rsp channel.
module adc24_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  adc24_pkg::rsp_type  push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output adc24_pkg::rsp_type  out_data
);

   logic                out_valid_ff, skid_valid_ff;
   adc24_pkg::rsp_type  out_data_ff, skid_data_ff;
   logic                take;

   assign take      = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no push while the skid entry is occupied; drain it on a take
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_data_ff <= push_data;
         end else begin
            skid_data_ff <= push_data;
         end
      end
   end

endmodule

@@ hdl/adc_24bit_serial_reader.sv @@
// Top level of the 24-bit serial converter reader: registers, sequencer, result buffer.
// A result beat is registered in the output stage, or the skid entry if rsp_ stalls.
// Throughput: one req_ beat per clock while req_stall is low.
// A stalled rsp_ side is absorbed by one skid entry, after which req_stall rises.
// Reset (synchronous, active high) idles the sequencer, powers the converter
// down, clears the last sample and loads the timeout and wake registers defaults.
module adc_24bit_serial_reader #(
   parameter int DATA_BITS = adc24_pkg::DATA_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [adc24_pkg::REQ_W-1:0]         req_type,
   input  logic                                req_data_pin,
   input  logic                                req_ms_strobe,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_clock_pin,
   output logic                                rsp_power_pin,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_status,
   output logic signed [adc24_pkg::OUT_W-1:0]  rsp_sample_value,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [adc24_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [adc24_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   adc24_pkg::cfg_type  cfg_ff;
   adc24_pkg::rsp_type  seq_rsp, buf_rsp;
   logic                accept, buf_full;

   // Take a beat whenever the skid entry is free
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // Configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_timeout_ms <= adc24_pkg::READ_TIMEOUT_RST;
         cfg_ff.init_timeout_ms <= adc24_pkg::INIT_TIMEOUT_RST;
         cfg_ff.wake_delay_ms   <= adc24_pkg::WAKE_DELAY_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            adc24_pkg::CSR_READ_TIMEOUT:
               cfg_ff.read_timeout_ms <= csr_wdata[adc24_pkg::MS_W-1:0];
            adc24_pkg::CSR_INIT_TIMEOUT:
               cfg_ff.init_timeout_ms <= csr_wdata[adc24_pkg::MS_W-1:0];
            adc24_pkg::CSR_WAKE_DELAY:
               cfg_ff.wake_delay_ms   <= csr_wdata[adc24_pkg::WAKE_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the pin sequencer once per accepted beat
   adc24_seq #(
      .DATA_BITS (DATA_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .req_type  (req_type),
      .data_pin  (req_data_pin),
      .ms_strobe (req_ms_strobe),
      .cfg       (cfg_ff),
      .rsp       (seq_rsp)
   );

   // Hold results until the rsp_ side takes them
   adc24_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (seq_rsp),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (buf_rsp)
   );

   assign rsp_clock_pin    = buf_rsp.clock_pin;
   assign rsp_power_pin    = buf_rsp.power_pin;
   assign rsp_busy_res     = buf_rsp.busy_res;
   assign rsp_done_res     = buf_rsp.done_res;
   assign rsp_status       = buf_rsp.status;
   assign rsp_sample_value = $signed(buf_rsp.sample_value);

endmodule

@@ tb/sv/adc_24bit_serial_reader_tb.sv @@
// Self-checking testbench for the 24-bit serial converter reader: pin-level shadow and random ticks.
module adc_24bit_serial_reader_tb;
   import adc24_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_BEATS = 225;
   // receiver holds off once after this many request beats
   localparam int unsigned HOLD_AFTER  = 500;
   localparam int unsigned HOLD_CYCLES = 120;

   // request codes past the last defined one; the block treats them as no request
   localparam logic [REQ_W-1:0]     REQ_BAD_LO = 3'd5;
   localparam logic [REQ_W-1:0]     REQ_BAD_HI = 3'd7;
   // index past the last register; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   localparam logic [OUT_W-1:0] WORD_MIN  = 24'h800000;
   localparam logic [OUT_W-1:0] WORD_MAX  = 24'h7FFFFF;
   localparam logic [OUT_W-1:0] WORD_ONES = 24'hFFFFFF;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_WAIT, S_RD_HIGH, S_RD_SAMPLE, S_EXTRA_HIGH, S_EXTRA_LOW,
      S_WAKE, S_INIT_PD, S_INIT_WAKE, S_INIT_WAIT
   } seq_state_e;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

   // one pin-level tick as offered on the request channel
   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic             pin;
      logic             strobe;
   } tick_beat_t;

   // Shadow of the converter sequencer: tracks pins, timers and the last sample,
   // queues the pin levels each accepted tick must produce and checks them in order.
   class reader_shadow;
      logic [MS_W-1:0]   read_limit;
      logic [MS_W-1:0]   init_limit;
      logic [WAKE_W-1:0] wake_hold;
      seq_state_e        state;
      logic [OUT_W-1:0]  shift_word;
      logic [OUT_W-1:0]  last_word;
      logic [4:0]        bit_cnt;
      logic [MS_W-1:0]   ms_count;
      logic              clk_lvl;
      logic              pwr_lvl;
      rsp_type           expected_pins[$];
      int unsigned       failures;
      int unsigned       checked;
      int unsigned       reads_done;
      int unsigned       timeouts;

      function new();
         read_limit = READ_TIMEOUT_RST;
         init_limit = INIT_TIMEOUT_RST;
         wake_hold  = WAKE_DELAY_RST;
         state      = S_IDLE;
         shift_word = '0;
         last_word  = '0;
         bit_cnt    = '0;
         ms_count   = '0;
         clk_lvl    = 1'b0;
         pwr_lvl    = 1'b0;
         failures   = 0;
         checked    = 0;
         reads_done = 0;
         timeouts   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_READ_TIMEOUT: read_limit = data;
            CSR_INIT_TIMEOUT: init_limit = data;
            CSR_WAKE_DELAY:   wake_hold  = data[WAKE_W-1:0];
            default: ;
         endcase
      endfunction

      function void count_ms(logic strobe);
         if (strobe && ms_count != MS_MAX) ms_count = ms_count + 1'b1;
      endfunction

      function void note_tick(tick_beat_t t);
         logic            done;
         logic            stat;
         logic [MS_W-1:0] limit;
         rsp_type         pins;
         done = 1'b0;
         stat = 1'b0;
         case (state)
            S_IDLE: begin
               case (t.kind)
                  REQ_READ: begin
                     ms_count = '0;
                     state    = S_RD_WAIT;
                  end
                  REQ_PDOWN: begin
                     clk_lvl = 1'b0;
                     pwr_lvl = 1'b0;
                     done    = 1'b1;
                  end
                  REQ_WAKE: begin
                     pwr_lvl  = 1'b1;
                     ms_count = '0;
                     state    = S_WAKE;
                  end
                  REQ_INIT: begin
                     clk_lvl = 1'b0;
                     pwr_lvl = 1'b0;
                     state   = S_INIT_PD;
                  end
                  default: ;
               endcase
            end
            S_RD_WAIT, S_INIT_WAIT: begin
               if (!t.pin) begin
                  // ready seen: a read raises the clock for its first bit right away
                  if (state == S_RD_WAIT) begin
                     shift_word = '0;
                     bit_cnt    = '0;
                     clk_lvl    = 1'b1;
                     state      = S_RD_SAMPLE;
                  end else begin
                     done  = 1'b1;
                     state = S_IDLE;
                  end
               end else begin
                  count_ms(t.strobe);
                  limit = (state == S_RD_WAIT) ? read_limit : init_limit;
                  if (ms_count >= limit) begin
                     done  = 1'b1;
                     stat  = 1'b1;
                     state = S_IDLE;
                     timeouts++;
                  end
               end
            end
            S_RD_HIGH: begin
               clk_lvl = 1'b1;
               state   = S_RD_SAMPLE;
            end
            S_RD_SAMPLE: begin
               shift_word = {shift_word[OUT_W-2:0], t.pin};
               clk_lvl    = 1'b0;
               bit_cnt    = bit_cnt + 1'b1;
               state      = (bit_cnt >= 5'(OUT_W)) ? S_EXTRA_HIGH : S_RD_HIGH;
            end
            S_EXTRA_HIGH: begin
               clk_lvl = 1'b1;
               state   = S_EXTRA_LOW;
            end
            S_EXTRA_LOW: begin
               // word is exactly as wide as the output, so sign extension keeps it as is
               last_word = shift_word;
               clk_lvl   = 1'b0;
               done      = 1'b1;
               state     = S_IDLE;
               reads_done++;
            end
            S_WAKE, S_INIT_WAKE: begin
               count_ms(t.strobe);
               if (ms_count >= {{(MS_W-WAKE_W){1'b0}}, wake_hold}) begin
                  if (state == S_WAKE) begin
                     done  = 1'b1;
                     state = S_IDLE;
                  end else begin
                     ms_count = '0;
                     state    = S_INIT_WAIT;
                  end
               end
            end
            S_INIT_PD: begin
               pwr_lvl  = 1'b1;
               ms_count = '0;
               state    = S_INIT_WAKE;
            end
            default: state = S_IDLE;
         endcase
         pins.clock_pin    = clk_lvl;
         pins.power_pin    = pwr_lvl;
         pins.busy_res     = (state != S_IDLE);
         pins.done_res     = done;
         pins.status       = stat;
         pins.sample_value = last_word;
         expected_pins.push_back(pins);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
         end
      endfunction

      function void check_pins(rsp_type seen);
         rsp_type want;
         if (expected_pins.size() == 0) begin
            $error("result beat with no tick waiting for it");
            failures++;
            return;
         end
         want = expected_pins.pop_front();
         checked++;
         compare_field("clock_pin", want.clock_pin, seen.clock_pin);
         compare_field("power_pin", want.power_pin, seen.power_pin);
         compare_field("busy_res", want.busy_res, seen.busy_res);
         compare_field("done_res", want.done_res, seen.done_res);
         compare_field("status", want.status, seen.status);
         compare_field("sample_value", $signed(want.sample_value), $signed(seen.sample_value));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_stall;
   logic [REQ_W-1:0]      req_type;
   logic                  req_data_pin;
   logic                  req_ms_strobe;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_clock_pin;
   logic                  rsp_power_pin;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic                  rsp_status;
   logic signed [OUT_W-1:0] rsp_sample_value;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   reader_shadow shadow;
   tick_beat_t   stim_q[$];
   rsp_type      seen_pins;
   int unsigned  beats_sent     = 0;
   int unsigned  cycle_count    = 0;
   bit           long_hold_done = 1'b0;

   adc_24bit_serial_reader dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_data_pin     (req_data_pin),
      .req_ms_strobe    (req_ms_strobe),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clock_pin    (rsp_clock_pin),
      .rsp_power_pin    (rsp_power_pin),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_sample_value (rsp_sample_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Tick generation. Sequences are built from the shadow's current register
   // copy so that reads get past the ready wait and wakes run out their delay;
   // busy ticks carry a rare random request that the block must ignore.
   // ---------------------------------------------------------------------------
   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [REQ_W-1:0] noise_kind();
      return ($urandom_range(0, 7) == 0) ? REQ_W'($urandom_range(0, 7)) : REQ_NONE;
   endfunction

   function automatic void push_tick(logic [REQ_W-1:0] kind, logic pin, logic strobe);
      tick_beat_t b;
      b.kind   = kind;
      b.pin    = pin;
      b.strobe = strobe;
      stim_q.push_back(b);
   endfunction

   // Hold the pin high for a while, then drop it. With a small limit, sometimes
   // keep it high long enough and strobe densely so the wait times out.
   function automatic void gen_ready_wait(logic [MS_W-1:0] limit);
      int unsigned n;
      bit          dense;
      dense = (limit <= 40) && ($urandom_range(0, 3) == 0);
      n     = dense ? 2 * limit + 3 : $urandom_range(0, 5);
      for (int unsigned i = 0; i < n; i++)
         push_tick(noise_kind(), 1'b1, dense ? ($urandom_range(0, 3) != 0) : coin());
      push_tick(noise_kind(), 1'b0, coin());
   endfunction

   // Advance until enough strobes have gone by to end the wake delay.
   function automatic void gen_power_hold(logic [WAKE_W-1:0] hold);
      int unsigned seen;
      bit          dense;
      logic        s;
      seen  = 0;
      dense = (hold > 16);
      do begin
         s = dense ? ($urandom_range(0, 15) != 0) : coin();
         push_tick(noise_kind(), coin(), s);
         if (s) seen++;
      end while (seen < hold);
   endfunction

   function automatic void gen_sequence();
      int unsigned      pick;
      logic [OUT_W-1:0] word;
      pick = $urandom_range(0, 99);
      // long wake delays cost hundreds of ticks: thin out wakes and inits then
      if (shadow.wake_hold > 16 && pick >= 55 && pick < 79 && $urandom_range(0, 3) != 0)
         pick = 0;
      if (pick < 45) begin
         push_tick(REQ_READ, coin(), coin());
         gen_ready_wait(shadow.read_limit);
         case ($urandom_range(0, 7))
            0:       word = WORD_MIN;
            1:       word = WORD_MAX;
            2:       word = WORD_ONES;
            3:       word = '0;
            default: word = OUT_W'($urandom);
         endcase
         // sample ticks carry the word MSB first; clock-high ticks in between
         for (int k = OUT_W - 1; k >= 0; k--) begin
            push_tick(noise_kind(), word[k], coin());
            if (k != 0) push_tick(noise_kind(), coin(), coin());
         end
         push_tick(noise_kind(), coin(), coin());
         push_tick(noise_kind(), coin(), coin());
      end else if (pick < 55) begin
         push_tick(REQ_PDOWN, coin(), coin());
      end else if (pick < 67) begin
         push_tick(REQ_WAKE, coin(), coin());
         gen_power_hold(shadow.wake_hold);
      end else if (pick < 79) begin
         push_tick(REQ_INIT, coin(), coin());
         push_tick(noise_kind(), coin(), coin());
         gen_power_hold(shadow.wake_hold);
         gen_ready_wait(shadow.init_limit);
      end else begin
         // unshaped ticks: any code, any pin, breaks sequences at random points
         repeat ($urandom_range(1, 6)) push_tick(REQ_W'($urandom_range(0, 7)), coin(), coin());
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------
   // Offer queued ticks in bursts; hold each beat until it is taken.
   task automatic play_stimulus();
      tick_beat_t  b;
      int unsigned burst;
      int unsigned gap;
      while (stim_q.size() != 0) begin
         burst = $urandom_range(1, 40);
         while (burst != 0 && stim_q.size() != 0) begin
            b = stim_q.pop_front();
            req_valid     <= 1'b1;
            req_type      <= b.kind;
            req_data_pin  <= b.pin;
            req_ms_strobe <= b.strobe;
            do @(posedge clock); while (req_stall);
            beats_sent++;
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Advance the clock first so the last accepted beat is noted before the queue is judged.
   task automatic drain();
      @(posedge clock);
      while (shadow.expected_pins.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      shadow.write_reg(idx, data);
   endtask

   // Write all three registers plus the unused index; the block is drained here.
   task automatic apply_settings(logic [CSR_DATA_W-1:0] rd_to, logic [CSR_DATA_W-1:0] in_to,
                                 logic [CSR_DATA_W-1:0] wake);
      csr_write(CSR_READ_TIMEOUT, rd_to);
      csr_write(CSR_INIT_TIMEOUT, in_to);
      csr_write(CSR_WAKE_DELAY, wake);
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random();
      while (stim_q.size() < PHASE_BEATS) gen_sequence();
      play_stimulus();
      drain();
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] rd_to, logic [CSR_DATA_W-1:0] in_to,
                            logic [CSR_DATA_W-1:0] wake);
      apply_settings(rd_to, in_to, wake);
      run_random();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      shadow = new();
      req_valid     <= 1'b0;
      req_type      <= REQ_NONE;
      req_data_pin  <= 1'b1;
      req_ms_strobe <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_READ_TIMEOUT;
      csr_wdata     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset register values: unknown codes, power down, a wake
      // whose request-tick strobe must not count, a request while busy, a quick init.
      push_tick(REQ_NONE, 1'b1, 1'b1);
      push_tick(REQ_BAD_LO, 1'b0, 1'b1);
      push_tick(REQ_W'(REQ_BAD_LO + 1'b1), 1'b1, 1'b0);
      push_tick(REQ_BAD_HI, 1'b0, 1'b1);
      push_tick(REQ_PDOWN, 1'b1, 1'b0);
      push_tick(REQ_WAKE, 1'b1, 1'b1);
      push_tick(REQ_NONE, 1'b1, 1'b1);
      push_tick(REQ_READ, 1'b1, 1'b1);
      push_tick(REQ_INIT, 1'b0, 1'b1);
      push_tick(REQ_NONE, 1'b0, 1'b1);
      push_tick(REQ_NONE, 1'b1, 1'b1);
      push_tick(REQ_NONE, 1'b1, 1'b1);
      push_tick(REQ_NONE, 1'b0, 1'b0);
      play_stimulus();
      drain();

      // Directed, all limits zero: wake ends on the next tick, init and read
      // time out on their first high-pin wait tick, power down while busy is dropped.
      apply_settings('0, '0, '0);
      push_tick(REQ_WAKE, 1'b1, 1'b0);
      push_tick(REQ_NONE, 1'b1, 1'b0);
      push_tick(REQ_INIT, 1'b1, 1'b0);
      push_tick(REQ_NONE, 1'b1, 1'b0);
      push_tick(REQ_NONE, 1'b1, 1'b0);
      push_tick(REQ_NONE, 1'b1, 1'b0);
      push_tick(REQ_READ, 1'b0, 1'b0);
      push_tick(REQ_PDOWN, 1'b1, 1'b0);
      push_tick(REQ_PDOWN, 1'b0, 1'b1);
      play_stimulus();
      drain();

      // Random phases across several register settings, extremes included;
      // the wake value of all ones checks masking to the register width.
      run_random();
      run_phase(10'd4, 10'd6, 10'd1);
      run_phase(10'd1023, 10'd1023, 10'h3FF);
      run_phase(CSR_DATA_W'($urandom_range(0, 1023)), CSR_DATA_W'($urandom_range(0, 1023)),
                CSR_DATA_W'($urandom_range(0, 1023)));
      run_phase(CSR_DATA_W'($urandom_range(0, 30)), CSR_DATA_W'($urandom_range(0, 30)),
                CSR_DATA_W'($urandom_range(0, 5)));
      run_phase(READ_TIMEOUT_RST, INIT_TIMEOUT_RST, WAKE_DELAY_RST);

      // let any stray result beat show up before judging
      repeat (8) @(posedge clock);
      $display("Ran %0d ticks over seven register settings with random idling and one long hold-off.",
               shadow.checked);
      $display("Covered %0d completed reads and %0d ready timeouts.",
               shadow.reads_done, shadow.timeouts);
      if (shadow.failures == 0) begin
         $display("[adc_24bit_serial_reader] OK");
      end else begin
         $display("[adc_24bit_serial_reader] ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall in patterns of random length; once, hold off long enough
   // for the skid entry to fill and the request side to stall.
   // ---------------------------------------------------------------------------
   initial begin
      stall_mode_e mode;
      int unsigned span;
      rsp_stall <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && beats_sent >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = stall_mode_e'($urandom_range(0, 2));
            span = $urandom_range(10, 60);
            for (int unsigned i = 0; i < span; i++) begin
               @(posedge clock);
               case (mode)
                  STALL_NONE:   rsp_stall <= 1'b0;
                  STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
                  default:      rsp_stall <= (i % 4 == 3);
               endcase
            end
         end
      end
   end

   // Note accepted ticks before checking so that either latency lines up.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            shadow.note_tick({req_type, req_data_pin, req_ms_strobe});
         if (rsp_valid && !rsp_stall) begin
            seen_pins = {rsp_clock_pin, rsp_power_pin, rsp_busy_res, rsp_done_res,
                         rsp_status, rsp_sample_value};
            shadow.check_pins(seen_pins);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[adc_24bit_serial_reader] ERROR");
         $finish;
      end
   end

endmodule
